// File: rtl/tps_pkg.sv
// Shared types, constants and byte-class functions of the text pattern search unit.
package tps_pkg;

   localparam int MAX_PATTERN   = 16;
   localparam int POSITION_BITS = 32;
   localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
   localparam int WIN_DEPTH     = MAX_PATTERN + 1;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;

   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_PATTERN_LEN  = 3'd2,
      CSR_IGNORE_CASE  = 3'd3,
      CSR_WHOLE_WORD   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       region_end;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] match_offset;
      logic [31:0] lines_passed;
   } rsp_type;

   // effective search setup handed to the compare logic
   typedef struct packed {
      logic [127:0]     pattern;
      logic [LEN_W-1:0] length;
      logic             ignore_case;
   } match_cfg_type;

   typedef struct packed {
      logic hit;
      logic prior_word;
   } match_type;

   typedef logic [WIN_DEPTH-1:0][7:0] window_type;

   function automatic logic is_word(input logic [7:0] b);
      return ((b >= CHAR_DIGIT_0) && (b <= CHAR_DIGIT_9)) ||
             ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
             ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) ||
             (b == CHAR_UNDERSCORE);
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] b, input logic ic);
      if (ic && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
         return b - CHAR_UPPER_A + CHAR_LOWER_A;
      end
      return b;
   endfunction

endpackage

// File: rtl/tps_window_match.sv
// Parallel compare of the byte window against the configured pattern.
module tps_window_match (
   input  tps_pkg::window_type    window,
   input  tps_pkg::match_cfg_type cfg,
   output tps_pkg::match_type     result
);
   import tps_pkg::*;

   logic [MAX_PATTERN-1:0][7:0] pat;
   logic [MAX_PATTERN-1:0]      lane_ok;

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (k < 16) begin
            pat[k] = cfg.pattern[8*k +: 8];
         end else begin
            pat[k] = 8'h00;
         end
      end
   end

   // window entry 0 is the newest byte; pattern byte k sits at entry length-1-k
   always_comb begin
      logic [LEN_W-1:0] idx;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         idx = LEN_W'(cfg.length - LEN_W'(k + 1));
         if (LEN_W'(k) < cfg.length) begin
            lane_ok[k] = (fold(window[idx], cfg.ignore_case) == pat[k]);
         end else begin
            lane_ok[k] = 1'b1;
         end
      end
   end

   assign result.hit        = &lane_ok;
   assign result.prior_word = is_word(window[cfg.length]);

endmodule

// File: rtl/text_pattern_search_unit.sv
// Top level of the streaming text pattern search unit.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_item : text_byte, region_end
//   rsp      out        rsp_valid / rsp_ready   rsp_item : found, match_offset, lines_passed
//   csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// One byte per cycle sustained while no result is stalled. A byte is captured in
// the input stage, and the window compare and region state update happen as it
// leaves that stage, which also loads the result register.
// csr_ready is always high. Reset clears the control state and loads register
// defaults; no clearing pass. A stalled result holds the input stage only.
module text_pattern_search_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tps_pkg::req_type                  req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tps_pkg::rsp_type                  rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                       csr_data
);
   import tps_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   logic [63:0] pat_low_ff, pat_high_ff;
   logic [4:0]  pat_len_ff;
   logic        ignore_case_ff, whole_word_ff;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   logic [MAX_PATTERN-1:0][7:0] recent_ff, recent_in;
   logic [POSITION_BITS-1:0]    pos_ff, pos_in;
   logic [31:0]                 nl_ff, nl_in;
   logic                        cand_pending_ff, cand_pending_in;
   logic [31:0]                 cand_offset_ff, cand_offset_in;
   logic [31:0]                 cand_lines_ff, cand_lines_in;
   logic                        done_ff, done_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;

   logic             proc_go;
   logic [LEN_W-1:0] eff_len;
   window_type       window;
   match_cfg_type    mcfg;
   match_type        mres;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff     <= '0;
         pat_high_ff    <= '0;
         pat_len_ff     <= 5'd1;
         ignore_case_ff <= 1'b0;
         whole_word_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_LOW: begin
               pat_low_ff <= csr_data;
            end
            CSR_PATTERN_HIGH: begin
               pat_high_ff <= csr_data;
            end
            CSR_PATTERN_LEN: begin
               pat_len_ff <= csr_data[4:0];
            end
            CSR_IGNORE_CASE: begin
               ignore_case_ff <= csr_data[0];
            end
            CSR_WHOLE_WORD: begin
               whole_word_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (pat_len_ff == 5'd0) begin
         eff_len = LEN_W'(1);
      end else if (32'(pat_len_ff) > 32'(MAX_PATTERN)) begin
         eff_len = LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = LEN_W'(pat_len_ff);
      end
   end

   // handshake
   assign proc_go   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_go;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   // window after shifting in the current byte
   assign window = {recent_ff, in_item_ff.text_byte};

   assign mcfg.pattern     = {pat_high_ff, pat_low_ff};
   assign mcfg.length      = eff_len;
   assign mcfg.ignore_case = ignore_case_ff;

   tps_window_match u_match (
      .window (window),
      .cfg    (mcfg),
      .result (mres)
   );

   // region state and result
   always_comb begin
      logic                     last;
      logic [7:0]               b;
      logic                     emit;
      logic                     hit;
      logic [POSITION_BITS-1:0] len_ext;
      logic [POSITION_BITS-1:0] off;

      last            = in_item_ff.region_end;
      b               = in_item_ff.text_byte;
      emit            = 1'b0;
      hit             = 1'b0;
      len_ext         = POSITION_BITS'(eff_len);
      off             = '0;
      recent_in       = recent_ff;
      pos_in          = pos_ff;
      nl_in           = nl_ff;
      cand_pending_in = cand_pending_ff;
      cand_offset_in  = cand_offset_ff;
      cand_lines_in   = cand_lines_ff;
      done_in         = done_ff;
      rsp_item_in     = rsp_item_ff;

      if (proc_go && !done_ff) begin
         recent_in = window[MAX_PATTERN-1:0];
         if ((b == CHAR_NEWLINE) && (nl_ff != CNT_MAX)) begin
            nl_in = nl_ff + 32'd1;
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POSITION_BITS'(1);
         end

         if (cand_pending_ff) begin
            cand_pending_in = 1'b0;
            if (!is_word(b)) begin
               emit                      = 1'b1;
               rsp_item_in.found         = 1'b1;
               rsp_item_in.match_offset  = cand_offset_ff;
               rsp_item_in.lines_passed  = cand_lines_ff;
            end
         end

         if (!emit && (pos_in >= len_ext)) begin
            hit = mres.hit;
            if (whole_word_ff && (pos_in != len_ext) && mres.prior_word) begin
               hit = 1'b0;
            end
            if (hit) begin
               off = pos_in - len_ext;
               if (!whole_word_ff || last) begin
                  emit                     = 1'b1;
                  rsp_item_in.found        = 1'b1;
                  rsp_item_in.match_offset = 32'(off);
                  rsp_item_in.lines_passed = nl_in;
               end else begin
                  cand_pending_in = 1'b1;
                  cand_offset_in  = 32'(off);
                  cand_lines_in   = nl_in;
               end
            end
         end

         if (!emit && last) begin
            emit                     = 1'b1;
            rsp_item_in.found        = 1'b0;
            rsp_item_in.match_offset = '0;
            rsp_item_in.lines_passed = nl_in;
         end

         if (emit) begin
            done_in = 1'b1;
         end
      end

      // region end clears region state whether or not a result was given
      if (proc_go && last) begin
         pos_in          = '0;
         nl_in           = '0;
         cand_pending_in = 1'b0;
         cand_offset_in  = '0;
         cand_lines_in   = '0;
         done_in         = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (proc_go && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         nl_ff           <= '0;
         cand_pending_ff <= 1'b0;
         cand_offset_ff  <= '0;
         cand_lines_ff   <= '0;
         done_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pos_ff          <= pos_in;
         nl_ff           <= nl_in;
         cand_pending_ff <= cand_pending_in;
         cand_offset_ff  <= cand_offset_in;
         cand_lines_ff   <= cand_lines_in;
         done_ff         <= done_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      recent_ff   <= recent_in;
      rsp_item_ff <= rsp_item_in;
   end

   // checks
   a_notfound_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.found) |-> (rsp_item_ff.match_offset == 32'd0))
      else $error("not-found result with nonzero offset");

   a_pending_not_done: assert property (@(posedge clock) disable iff (reset)
      cand_pending_ff |-> !done_ff)
      else $error("candidate pending after search finished");

   a_pending_whole_word: assert property (@(posedge clock) disable iff (reset)
      cand_pending_ff |-> whole_word_ff)
      else $error("candidate pending without whole-word mode");

   a_done_no_result: assert property (@(posedge clock) disable iff (reset)
      (proc_go && done_ff && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result produced while skipping to region end");

endmodule

// File: dv/text_pattern_search_unit_test.sv
// Testbench for the text pattern search unit: a directed table of regions, then random regions.
module text_pattern_search_unit_test;
   import tps_pkg::*;

   typedef struct {
      bit         write_cfg;
      string      pat;
      logic [4:0] len;
      bit         ic;
      bit         ww;
      string      text;
      bit         typed;
      rsp_type    want;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_item = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PATTERN_LOW;
   logic [63:0]            csr_data = '0;

   text_pattern_search_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // search setup as the block should hold it
   logic [127:0] pat_bytes   = '0;
   logic [4:0]   pat_len_reg = 5'd1;
   bit           fold_on     = 1'b0;
   bit           word_on     = 1'b0;

   // region state
   logic [7:0]   seen_bytes [WIN_DEPTH];
   logic [31:0]  byte_pos    = '0;
   logic [31:0]  newlines    = '0;
   bit           cand_wait   = 1'b0;
   logic [31:0]  cand_off    = '0;
   logic [31:0]  cand_lines  = '0;
   bit           scan_done   = 1'b0;

   rsp_type      pending_results [$];
   bit           typed_on    = 1'b0;
   rsp_type      typed_want  = '0;
   rsp_type      predicted;
   rsp_type      oldest;

   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           fails     = 0;
   int           n_bytes   = 0;
   int           n_regions = 0;
   int           n_checked = 0;
   int           n_setups  = 0;

   initial begin
      for (int k = 0; k < WIN_DEPTH; k++) seen_bytes[k] = '0;
   end

   function automatic bit word_class(input logic [7:0] b);
      return (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9) ||
             (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
             (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) || b == CHAR_UNDERSCORE;
   endfunction

   function automatic void clear_region();
      for (int k = 0; k < WIN_DEPTH; k++) seen_bytes[k] = '0;
      byte_pos   = '0;
      newlines   = '0;
      cand_wait  = 1'b0;
      cand_off   = '0;
      cand_lines = '0;
      scan_done  = 1'b0;
   endfunction

   // advance the search by one byte; returns 1 when a result is due
   function automatic bit search_next_byte(input logic [7:0] b, input logic last,
                                           output rsp_type res);
      int unsigned len;
      bit          hit;
      bit          emitted;
      logic [7:0]  tb;
      len = (pat_len_reg == 0) ? 1 : (pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : pat_len_reg;
      emitted = 1'b0;
      res = '0;
      if (scan_done) begin
         if (last) clear_region();
         return 1'b0;
      end
      for (int k = WIN_DEPTH - 1; k > 0; k--) seen_bytes[k] = seen_bytes[k-1];
      seen_bytes[0] = b;
      if (b == CHAR_NEWLINE && newlines != CNT_MAX) newlines++;
      if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
      if (cand_wait) begin
         cand_wait = 1'b0;
         if (!word_class(b)) begin
            res = '{found: 1'b1, match_offset: cand_off, lines_passed: cand_lines};
            emitted = 1'b1;
         end
      end
      if (!emitted && byte_pos >= len) begin
         hit = 1'b1;
         for (int unsigned k = 0; k < len; k++) begin
            tb = seen_bytes[len-1-k];
            if (fold_on && tb >= CHAR_UPPER_A && tb <= CHAR_UPPER_Z)
               tb = tb - CHAR_UPPER_A + CHAR_LOWER_A;
            if (tb != pat_bytes[8*k +: 8]) hit = 1'b0;
         end
         if (hit && word_on && byte_pos != len && word_class(seen_bytes[len])) hit = 1'b0;
         if (hit) begin
            if (!word_on || last) begin
               res = '{found: 1'b1, match_offset: byte_pos - len, lines_passed: newlines};
               emitted = 1'b1;
            end else begin
               cand_wait  = 1'b1;
               cand_off   = byte_pos - len;
               cand_lines = newlines;
            end
         end
      end
      if (!emitted && last) begin
         res = '{found: 1'b0, match_offset: '0, lines_passed: newlines};
         emitted = 1'b1;
      end
      if (emitted) scan_done = 1'b1;
      if (last) clear_region();
      return emitted;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PATTERN_LOW:  pat_bytes[63:0]   = csr_data;
               CSR_PATTERN_HIGH: pat_bytes[127:64] = csr_data;
               CSR_PATTERN_LEN:  pat_len_reg       = csr_data[4:0];
               CSR_IGNORE_CASE:  fold_on           = csr_data[0];
               CSR_WHOLE_WORD:   word_on           = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            n_bytes++;
            if (req_item.region_end) n_regions++;
            if (search_next_byte(req_item.text_byte, req_item.region_end, predicted))
               pending_results.push_back(typed_on ? typed_want : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: found=%0d offset=%0d lines=%0d",
                      rsp_item.found, rsp_item.match_offset, rsp_item.lines_passed);
               fails++;
            end else begin
               oldest = pending_results.pop_front();
               n_checked++;
               if (rsp_item.found !== oldest.found) begin
                  $error("found: expected %0d, got %0d", oldest.found, rsp_item.found);
                  fails++;
               end
               if (rsp_item.match_offset !== oldest.match_offset) begin
                  $error("match_offset: expected %0d, got %0d",
                         oldest.match_offset, rsp_item.match_offset);
                  fails++;
               end
               if (rsp_item.lines_passed !== oldest.lines_passed) begin
                  $error("lines_passed: expected %0d, got %0d",
                         oldest.lines_passed, rsp_item.lines_passed);
                  fails++;
               end
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{text_byte: b, region_end: last};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
   endtask

   // upper bits of the narrow registers carry noise; only the low bits count
   task automatic load_search_setup(input logic [127:0] pat, input logic [4:0] len,
                                    input bit ic, input bit ww);
      logic [63:0] v;
      write_reg(CSR_PATTERN_LOW, pat[63:0]);
      write_reg(CSR_PATTERN_HIGH, pat[127:64]);
      v = {$urandom, $urandom};
      v[4:0] = len;
      write_reg(CSR_PATTERN_LEN, v);
      v = {$urandom, $urandom};
      v[0] = ic;
      write_reg(CSR_IGNORE_CASE, v);
      v = {$urandom, $urandom};
      v[0] = ww;
      write_reg(CSR_WHOLE_WORD, v);
      csr_valid <= 1'b0;
      n_setups++;
   endtask

   // bytes after a result produce nothing, so allow the pipeline to empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] boundary_byte();
      case ($urandom_range(0, 4))
         0: return 8'h20;
         1: return CHAR_NEWLINE;
         2: return CHAR_UNDERSCORE;
         3: return 8'h2E;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic logic [7:0] flip_case(input logic [7:0] b, input bit ic);
      if (ic && b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z && $urandom_range(0, 1))
         return b - CHAR_LOWER_A + CHAR_UPPER_A;
      return b;
   endfunction

   function automatic logic [7:0] pattern_pick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return CHAR_LOWER_A + 8'($urandom_range(0, 2));
      if (r < 75) return boundary_byte();
      if (r < 90) return 8'($urandom_range(0, 255));
      return CHAR_UPPER_A + 8'($urandom_range(0, 2));
   endfunction

   function automatic logic [7:0] filler_byte(input logic [127:0] pat, input int L,
                                              input bit ic);
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return 8'($urandom_range(0, 255));
      if (r < 30) return boundary_byte();
      return flip_case(pat[8*$urandom_range(0, L-1) +: 8], ic);
   endfunction

   dir_row_type dir_rows [19] = '{
      '{1'b0, "",      5'd1, 1'b0, 1'b0, "ab\n",       1'b1, '{1'b0, 32'd0, 32'd1}},
      '{1'b1, "abc",   5'd3, 1'b0, 1'b0, "xxabc",      1'b1, '{1'b1, 32'd2, 32'd0}},
      '{1'b1, "abcd",  5'd4, 1'b0, 1'b0, "abc",        1'b1, '{1'b0, 32'd0, 32'd0}},
      '{1'b1, "hello", 5'd5, 1'b1, 1'b0, "\nHeLLo",    1'b1, '{1'b1, 32'd1, 32'd1}},
      '{1'b1, "hello", 5'd5, 1'b0, 1'b0, "\nHeLLo",    1'b1, '{1'b0, 32'd0, 32'd1}},
      '{1'b1, "ABC",   5'd3, 1'b1, 1'b0, "ABC",        1'b1, '{1'b0, 32'd0, 32'd0}},
      '{1'b1, "cat",   5'd3, 1'b0, 1'b1, "concat cat.", 1'b1, '{1'b1, 32'd7, 32'd0}},
      '{1'b1, "ab",    5'd2, 1'b0, 1'b1, "abc ab",     1'b1, '{1'b1, 32'd4, 32'd0}},
      '{1'b1, "ab",    5'd2, 1'b0, 1'b1, "abc",        1'b1, '{1'b0, 32'd0, 32'd0}},
      '{1'b1, "ok",    5'd2, 1'b0, 1'b1, "\377ok\200", 1'b1, '{1'b1, 32'd1, 32'd0}},
      '{1'b1, "ok",    5'd2, 1'b0, 1'b1, "_ok ok",     1'b1, '{1'b1, 32'd4, 32'd0}},
      '{1'b1, "q",     5'd0, 1'b0, 1'b0, "xq",         1'b1, '{1'b1, 32'd1, 32'd0}},
      '{1'b1, "0123456789abcdef", 5'd31, 1'b0, 1'b0, "-0123456789abcdef",
        1'b1, '{1'b1, 32'd1, 32'd0}},
      '{1'b1, "0123456789abcdef", 5'd16, 1'b1, 1'b1, "0123456789ABCDEF",
        1'b1, '{1'b1, 32'd0, 32'd0}},
      '{1'b1, "a",     5'd1, 1'b0, 1'b0, "aaaa",       1'b1, '{1'b1, 32'd0, 32'd0}},
      '{1'b1, "x",     5'd1, 1'b0, 1'b0, "\n\nx\n",    1'b1, '{1'b1, 32'd2, 32'd2}},
      '{1'b1, "z",     5'd1, 1'b0, 1'b0, "z",          1'b1, '{1'b1, 32'd0, 32'd0}},
      '{1'b1, "aab",   5'd3, 1'b0, 1'b0, "aaab\nb",    1'b0, '{1'b0, 32'd0, 32'd0}},
      '{1'b1, "the",   5'd3, 1'b1, 1'b1, "The\tthe_ THE", 1'b0, '{1'b0, 32'd0, 32'd0}}
   };

   int unsigned phase_len [12] = '{1, 2, 3, 0, 16, 31, 4, 2, 5, 16, 1, 3};

   initial begin
      logic [127:0] pat;
      logic [7:0]   region_q [$];
      int           L;
      int           n;
      int           m;
      int           r;
      int           sent;
      bit           ic;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         wait_idle();
         if (dir_rows[i].write_cfg) begin
            pat = '0;
            for (int k = 0; k < dir_rows[i].pat.len(); k++) pat[8*k +: 8] = dir_rows[i].pat[k];
            load_search_setup(pat, dir_rows[i].len, dir_rows[i].ic, dir_rows[i].ww);
         end
         typed_on   = dir_rows[i].typed;
         typed_want = dir_rows[i].want;
         for (int k = 0; k < dir_rows[i].text.len(); k++)
            send_byte(dir_rows[i].text[k], k == dir_rows[i].text.len() - 1);
      end
      wait_idle();
      typed_on = 1'b0;

      for (int p = 0; p < 12; p++) begin
         send_idle_pct = (p < 4) ? 7 : (p < 8) ? 75 : 0;
         recv_idle_pct = (p < 4) ? 75 : (p < 8) ? 7 : 0;
         ic = p[0];
         if (p == 5) pat = '1;
         else for (int k = 0; k < 16; k++) pat[8*k +: 8] = pattern_pick();
         L = (phase_len[p] == 0) ? 1 : (phase_len[p] > MAX_PATTERN) ? MAX_PATTERN : phase_len[p];
         load_search_setup(pat, phase_len[p][4:0], ic, p[1]);
         sent = 0;
         while (sent < 26) begin
            region_q.delete();
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(L + 10, 3 * L + 30)
                                            : $urandom_range(1, L + 10);
            while (region_q.size() < n) begin
               r = $urandom_range(0, 99);
               if (r < 25) begin
                  // whole pattern most of the time, otherwise a broken prefix
                  m = (r < 17) ? L : $urandom_range(1, L);
                  for (int k = 0; k < m; k++) region_q.push_back(flip_case(pat[8*k +: 8], ic));
               end else begin
                  region_q.push_back(filler_byte(pat, L, ic));
               end
            end
            foreach (region_q[i]) send_byte(region_q[i], i == region_q.size() - 1);
            sent += region_q.size();
         end
         wait_idle();
      end

      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         fails++;
      end
      $display("searched %0d regions in %0d text bytes under %0d register setups",
               n_regions, n_bytes, n_setups);
      $display("compared %0d results, %0d mismatches", n_checked, fails);
      if (fails == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("status: fail");
      $finish;
   end

endmodule

// File: text_pattern_search_unit.f
rtl/tps_pkg.sv
rtl/tps_window_match.sv
rtl/text_pattern_search_unit.sv
dv/text_pattern_search_unit_test.sv
